FILE: rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared widths, opcodes, ASCII codes and digit helpers for the formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int OPCODE_W   = 3;
    localparam int CHAR_W     = 7;
    localparam int LEN_W      = 5;
    localparam int NUM_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);

    typedef logic [3:0] t_digit;

    localparam logic [OPCODE_W-1:0] OP_S32_DEC = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_U32_DEC = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_S64_DEC = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_U64_DEC = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_HEX_LO  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_HEX_UP  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;        // zero the digit
        logic bit_shift;    // shift one binary bit in, with decimal correction when dec is set
        logic digit_shift;  // take the lower neighbor's digit
        logic dec;          // decimal correction enabled
    } t_cell_ctl;

    // Add 3 to a BCD digit of 5 or more before it doubles.
    function automatic t_digit adjust_digit(input t_digit d, input logic dec);
        t_digit r;
        r = (dec && (d >= 4'd5)) ? t_digit'(d + 4'd3) : d;
        return r;
    endfunction

    // Bit that leaves a digit toward its upper neighbor on a bit shift.
    function automatic logic digit_carry(input t_digit d, input logic dec);
        t_digit a;
        a = adjust_digit(d, dec);
        return a[3];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input t_digit d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = (upper ? CH_UPPER_A : CH_LOWER_A) + {3'b000, t_digit'(d - 4'd10)};
        end
        return c;
    endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter.sv
// An accepted transaction shifts its magnitude into the digit chain, drops
// leading zeros, and then emits one character per cycle (sign first) while the
// output register is free; an output stall holds the character stream. A new
// transaction is accepted only once the last character has been emitted.
// Reset (i_rst_n low, synchronous) idles the controller and empties the output.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32- or 64-bit integer as signed/unsigned decimal, or 64 bits as hex ASCII.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [OPCODE_W-1:0] i_opcode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CHAR_W-1:0]   o_character,
    output logic                o_last,
    output logic [LEN_W-1:0]    o_length
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    localparam logic [SHIFT_CNT_W-1:0] LAST_SHIFT = SHIFT_CNT_W'(VALUE_W - 1);
    localparam logic [LEN_W-1:0]       DEC_CHARS  = LEN_W'(NUM_DIGITS);
    localparam logic [LEN_W-1:0]       HEX_CHARS  = LEN_W'(HEX_DIGITS);

    t_state                 r_state, n_state;
    logic [VALUE_W-1:0]     r_mag, n_mag;
    logic [SHIFT_CNT_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0]       r_rem, n_rem;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_neg, n_neg;
    logic                   r_hex, n_hex;
    logic                   r_upper, n_upper;

    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;
    logic [LEN_W-1:0]       r_length, n_length;

    logic                   accept;
    logic                   op_ok;
    logic                   slot_free;
    logic [31:0]            low_word;
    logic [VALUE_W-1:0]     load_mag;
    logic                   load_neg;
    t_cell_ctl              cell_ctl;
    t_digit                 top_dec, top_hex, top_digit;
    logic                   skipping;

    // Input is taken only between numbers; the output register decouples
    // the last character of one number from the next transaction.
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign op_ok      = (i_opcode <= OP_HEX_UP);
    assign slot_free  = !r_out_valid || i_out_ready;

    // Magnitude and sign at load; the two's-complement negation covers the
    // most negative value, which lands as its exact unsigned magnitude.
    assign low_word = i_value[31:0];
    always_comb begin
        load_neg = 1'b0;
        load_mag = i_value;
        case (i_opcode)
            OP_S32_DEC: begin
                load_neg = low_word[31];
                load_mag = {32'd0, low_word[31] ? 32'(32'd0 - low_word) : low_word};
            end
            OP_U32_DEC: begin
                load_mag = {32'd0, low_word};
            end
            OP_S64_DEC: begin
                load_neg = i_value[VALUE_W-1];
                load_mag = i_value[VALUE_W-1] ? VALUE_W'({VALUE_W{1'b0}} - i_value)
                                              : i_value;
            end
            default: begin
                load_mag = i_value;
            end
        endcase
    end

    // Leading zeros drop while more than one digit remains, so zero prints as '0'.
    assign top_digit = r_hex ? top_hex : top_dec;
    assign skipping  = (top_digit == 4'd0) && (r_rem > LEN_W'(1));

    always_comb begin
        cell_ctl.clear       = accept && op_ok;
        cell_ctl.bit_shift   = (r_state == ST_CONV);
        cell_ctl.digit_shift = ((r_state == ST_SKIP) && skipping) ||
                               ((r_state == ST_EMIT) && slot_free);
        cell_ctl.dec         = !r_hex;
    end

    i2a_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (cell_ctl),
        .i_serial  (r_mag[VALUE_W-1]),
        .o_top_dec (top_dec),
        .o_top_hex (top_hex)
    );

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_len       = r_len;
        n_neg       = r_neg;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_length    = r_length;

        unique case (r_state)
            ST_IDLE: begin
                // Drop transactions with an unused opcode.
                if (accept && op_ok) begin
                    n_mag   = load_mag;
                    n_neg   = load_neg;
                    n_hex   = (i_opcode == OP_HEX_LO) || (i_opcode == OP_HEX_UP);
                    n_upper = (i_opcode == OP_HEX_UP);
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // Advance one magnitude bit, MSB first, into the chain.
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + SHIFT_CNT_W'(1);
                if (r_cnt == LAST_SHIFT) begin
                    n_rem   = r_hex ? HEX_CHARS : DEC_CHARS;
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (skipping) begin
                    n_rem = r_rem - LEN_W'(1);
                end else begin
                    n_len   = r_rem + LEN_W'(r_neg);
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_length    = '0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register frees up, then emit the top digit.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_char(top_digit, r_upper);
                    n_last      = (r_rem == LEN_W'(1));
                    n_length    = (r_rem == LEN_W'(1)) ? r_len : '0;
                    n_rem       = r_rem - LEN_W'(1);
                    if (r_rem == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_len    <= n_len;
        r_neg    <= n_neg;
        r_hex    <= n_hex;
        r_upper  <= n_upper;
        r_char   <= n_char;
        r_last   <= n_last;
        r_length <= n_length;
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_length    = r_length;

`ifndef SYNTHESIS
    a_len_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_length == '0))
        else $error("nonzero length on a non-final character");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> ((o_length != '0) && (o_length <= DEC_CHARS)))
        else $error("final length out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_character == CH_MINUS)) |-> !o_last)
        else $error("minus sign flagged as final character");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) || (r_state == ST_SKIP)) |-> (r_rem != '0))
        else $error("digit count underflow");
`endif

endmodule

FILE: rtl/i2a_cell.sv
// ----------------------------------------------------------------------------
// i2a_cell
// One digit cell: clears, corrects and shifts in a bit, or takes its neighbor's digit.
// ----------------------------------------------------------------------------
module i2a_cell
    import i2a_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_bit,
    input  t_digit    i_digit,
    output t_digit    o_digit
);

    t_digit r_digit;
    t_digit n_digit;
    t_digit adj;

    assign adj = adjust_digit(r_digit, i_ctl.dec);

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.bit_shift) begin
            n_digit = {adj[2:0], i_bit};
        end else if (i_ctl.digit_shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

FILE: rtl/i2a_chain.sv
// ----------------------------------------------------------------------------
// i2a_chain
// Row of digit cells: binary bits enter at the bottom, digits leave at the top.
// ----------------------------------------------------------------------------
module i2a_chain
    import i2a_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_serial,
    output t_digit    o_top_dec,
    output t_digit    o_top_hex
);

    t_digit digits [NUM_DIGITS];

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
        logic   bit_in;
        t_digit digit_in;

        if (k == 0) begin : g_first
            assign bit_in   = i_serial;
            assign digit_in = '0;
        end else begin : g_rest
            assign bit_in   = digit_carry(digits[k-1], i_ctl.dec);
            assign digit_in = digits[k-1];
        end

        i2a_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (bit_in),
            .i_digit (digit_in),
            .o_digit (digits[k])
        );
    end

    assign o_top_dec = digits[NUM_DIGITS-1];
    assign o_top_hex = digits[HEX_DIGITS-1];

endmodule
